// ----- hdl/chs_pkg.sv -----
// Shared constants, register indexes and the harmonic offset helper for the
// harmonic shaper. No dependencies; every other file but chs_checker imports it.
package chs_pkg;

  localparam int CHANNELS        = 2;
  localparam int CH_LEFT         = 0;
  localparam int CH_RIGHT        = 1;

  localparam int CFG_INDEX_WIDTH = 4;
  localparam int CFG_DATA_WIDTH  = 64;
  localparam int LANE_WIDTH      = 16;
  localparam int MIX_WIDTH       = 16;
  localparam int MIX_FRAC        = 14;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHTS_LOW  = 4'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHTS_MID  = 4'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_WEIGHTS_HIGH = 4'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MIX_AMOUNT   = 4'd3;

  localparam logic [MIX_WIDTH-1:0] MIX_RESET = 16'd16384;

  // offset applied to T(n) to form the harmonic: none, +1.0 or -1.0
  localparam logic [1:0] ADJ_NONE = 2'd0;
  localparam logic [1:0] ADJ_ADD  = 2'd1;
  localparam logic [1:0] ADJ_SUB  = 2'd2;

  // even orders drop their constant term (-1)^(n/2)
  function automatic logic [1:0] chs_adjust(input int order);
    logic [1:0] m;
    logic [1:0] code;
    m = order[1:0];
    case (m)
      2'd2:    code = ADJ_ADD;
      2'd0:    code = ADJ_SUB;
      default: code = ADJ_NONE;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/chs_order_stage.sv -----
// One pipeline stage of the Chebyshev recurrence: computes T(ORDER) for both
// channels and folds the weighted harmonic of order ORDER-1 into the sum.
// Depends on chs_pkg.
module chs_order_stage #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int WEIGHT_WIDTH = 16,
  parameter int ORDER        = 2
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       up_valid,
  output logic                                       up_ready,
  output logic                                       dn_valid,
  input  logic                                       dn_ready,
  input  logic signed [WEIGHT_WIDTH-1:0]             gain_i,
  input  logic signed [SAMPLE_WIDTH-1:0]             x_i    [chs_pkg::CHANNELS],
  input  logic signed [SAMPLE_WIDTH:0]               prev_i [chs_pkg::CHANNELS],
  input  logic signed [SAMPLE_WIDTH:0]               cur_i  [chs_pkg::CHANNELS],
  input  logic signed [SAMPLE_WIDTH+WEIGHT_WIDTH+5:0] acc_i [chs_pkg::CHANNELS],
  output logic signed [SAMPLE_WIDTH-1:0]             x_o    [chs_pkg::CHANNELS],
  output logic signed [SAMPLE_WIDTH:0]               prev_o [chs_pkg::CHANNELS],
  output logic signed [SAMPLE_WIDTH:0]               cur_o  [chs_pkg::CHANNELS],
  output logic signed [SAMPLE_WIDTH+WEIGHT_WIDTH+5:0] acc_o [chs_pkg::CHANNELS]
);
  import chs_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int WW  = WEIGHT_WIDTH;
  localparam int TW  = SW + 1;
  localparam int PRW = 2 * SW + 1;
  localparam int DW  = SW + 4;
  localparam int HW  = SW + 2;
  localparam int PW  = HW + WW;
  localparam int AW  = PW + 4;

  localparam logic [1:0]            ADJ   = chs_adjust(ORDER - 1);
  localparam logic signed [PRW-1:0] RND   = PRW'(1) << (SW - 3);
  localparam logic signed [DW-1:0]  POS_D = DW'(1) << (SW - 1);
  localparam logic signed [DW-1:0]  NEG_D = -POS_D;
  localparam logic signed [TW-1:0]  POS_T = TW'(1) << (SW - 1);
  localparam logic signed [TW-1:0]  NEG_T = -POS_T;
  localparam logic signed [HW-1:0]  ONE_H = HW'(1) << (SW - 1);

  logic                  vld_r;
  logic signed [SW-1:0]  x_r      [CHANNELS];
  logic signed [SW-1:0]  x_nxt    [CHANNELS];
  logic signed [TW-1:0]  prev_r   [CHANNELS];
  logic signed [TW-1:0]  prev_nxt [CHANNELS];
  logic signed [TW-1:0]  cur_r    [CHANNELS];
  logic signed [TW-1:0]  cur_nxt  [CHANNELS];
  logic signed [AW-1:0]  acc_r    [CHANNELS];
  logic signed [AW-1:0]  acc_nxt  [CHANNELS];

  logic signed [PRW-1:0] prod [CHANNELS];
  logic signed [PRW-1:0] rsum [CHANNELS];
  logic signed [SW+2:0]  rnd  [CHANNELS];
  logic signed [DW-1:0]  dif  [CHANNELS];
  logic signed [HW-1:0]  harm [CHANNELS];
  logic signed [PW-1:0]  wp   [CHANNELS];

  assign up_ready = !vld_r || dn_ready;
  assign dn_valid = vld_r;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      // 2x*T(n-1): product rounded at F-1 fraction bits
      prod[c] = $signed({{TW{x_i[c][SW-1]}}, x_i[c]}) *
                $signed({{SW{cur_i[c][TW-1]}}, cur_i[c]});
      rsum[c] = prod[c] + RND;
      rnd[c]  = rsum[c][PRW-1:SW-2];
      dif[c]  = $signed({rnd[c][SW+2], rnd[c]}) -
                $signed({{3{prev_i[c][TW-1]}}, prev_i[c]});
      if (dif[c] > POS_D) begin
        cur_nxt[c] = POS_T;
      end else if (dif[c] < NEG_D) begin
        cur_nxt[c] = NEG_T;
      end else begin
        cur_nxt[c] = dif[c][TW-1:0];
      end

      // harmonic of the previous order, weighted into the running sum
      case (ADJ)
        ADJ_ADD: harm[c] = $signed({cur_i[c][TW-1], cur_i[c]}) + ONE_H;
        ADJ_SUB: harm[c] = $signed({cur_i[c][TW-1], cur_i[c]}) - ONE_H;
        default: harm[c] = $signed({cur_i[c][TW-1], cur_i[c]});
      endcase
      wp[c] = $signed({{WW{harm[c][HW-1]}}, harm[c]}) *
              $signed({{HW{gain_i[WW-1]}}, gain_i});
      acc_nxt[c]  = acc_i[c] + $signed({{(AW-PW){wp[c][PW-1]}}, wp[c]});
      x_nxt[c]    = x_i[c];
      prev_nxt[c] = cur_i[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      x_r    <= x_nxt;
      prev_r <= prev_nxt;
      cur_r  <= cur_nxt;
      acc_r  <= acc_nxt;
    end
  end

  assign x_o    = x_r;
  assign prev_o = prev_r;
  assign cur_o  = cur_r;
  assign acc_o  = acc_r;

endmodule

// ----- hdl/chs_mix_stage.sv -----
// Tail of the shaper pipeline: last weighted harmonic, rounding of the sum,
// mix scaling, add to the dry sample and saturation into the output register.
// Depends on chs_pkg.
module chs_mix_stage #(
  parameter int SAMPLE_WIDTH = 24,
  parameter int WEIGHT_WIDTH = 16,
  parameter int ORDER        = 13
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        up_valid,
  output logic                                        up_ready,
  output logic                                        dn_valid,
  input  logic                                        dn_ready,
  input  logic signed [WEIGHT_WIDTH-1:0]              gain_i,
  input  logic signed [chs_pkg::MIX_WIDTH-1:0]        mix_i,
  input  logic signed [SAMPLE_WIDTH-1:0]              x_i   [chs_pkg::CHANNELS],
  input  logic signed [SAMPLE_WIDTH:0]                cur_i [chs_pkg::CHANNELS],
  input  logic signed [SAMPLE_WIDTH+WEIGHT_WIDTH+5:0] acc_i [chs_pkg::CHANNELS],
  output logic signed [SAMPLE_WIDTH-1:0]              y_o   [chs_pkg::CHANNELS]
);
  import chs_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int WW  = WEIGHT_WIDTH;
  localparam int TW  = SW + 1;
  localparam int HW  = SW + 2;
  localparam int PW  = HW + WW;
  localparam int AW  = PW + 4;
  localparam int SDW = AW - (WW - 2);
  localparam int MPW = SDW + MIX_WIDTH;
  localparam int EW  = MPW - MIX_FRAC;
  localparam int YW  = EW + 1;
  localparam int NSUB = 4;

  localparam logic [1:0]            ADJ   = chs_adjust(ORDER);
  localparam logic signed [HW-1:0]  ONE_H = HW'(1) << (SW - 1);
  localparam logic signed [AW-1:0]  RND_A = AW'(1) << (WW - 3);
  localparam logic signed [MPW-1:0] RND_P = MPW'(1) << (MIX_FRAC - 1);
  localparam logic signed [YW-1:0]  MAX_Y = (YW'(1) << (SW - 1)) - YW'(1);
  localparam logic signed [YW-1:0]  MIN_Y = -(YW'(1) << (SW - 1));

  logic [NSUB-1:0] v_r;
  logic [NSUB-1:0] rdy;

  logic signed [SW-1:0]  xa_r   [CHANNELS];
  logic signed [AW-1:0]  acca_r [CHANNELS];
  logic signed [AW-1:0]  acca_nxt [CHANNELS];
  logic signed [SW-1:0]  xb_r   [CHANNELS];
  logic signed [SDW-1:0] sb_r   [CHANNELS];
  logic signed [SDW-1:0] sb_nxt [CHANNELS];
  logic signed [SW-1:0]  xc_r   [CHANNELS];
  logic signed [MPW-1:0] pc_r   [CHANNELS];
  logic signed [MPW-1:0] pc_nxt [CHANNELS];
  logic signed [SW-1:0]  y_r    [CHANNELS];
  logic signed [SW-1:0]  y_nxt  [CHANNELS];

  logic signed [HW-1:0]  harm [CHANNELS];
  logic signed [PW-1:0]  wp   [CHANNELS];
  logic signed [AW-1:0]  rs_a [CHANNELS];
  logic signed [MPW-1:0] rs_p [CHANNELS];
  logic signed [EW-1:0]  e    [CHANNELS];
  logic signed [YW-1:0]  ysum [CHANNELS];

  // a sub-stage advances when it is empty or the one after it advances
  always_comb begin
    rdy[NSUB-1] = !v_r[NSUB-1] || dn_ready;
    for (int i = NSUB - 2; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  assign up_ready = rdy[0];
  assign dn_valid = v_r[NSUB-1];

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      case (ADJ)
        ADJ_ADD: harm[c] = $signed({cur_i[c][TW-1], cur_i[c]}) + ONE_H;
        ADJ_SUB: harm[c] = $signed({cur_i[c][TW-1], cur_i[c]}) - ONE_H;
        default: harm[c] = $signed({cur_i[c][TW-1], cur_i[c]});
      endcase
      wp[c] = $signed({{WW{harm[c][HW-1]}}, harm[c]}) *
              $signed({{HW{gain_i[WW-1]}}, gain_i});
      acca_nxt[c] = acc_i[c] + $signed({{(AW-PW){wp[c][PW-1]}}, wp[c]});

      rs_a[c]   = acca_r[c] + RND_A;
      sb_nxt[c] = rs_a[c][AW-1:WW-2];

      pc_nxt[c] = $signed({{MIX_WIDTH{sb_r[c][SDW-1]}}, sb_r[c]}) *
                  $signed({{SDW{mix_i[MIX_WIDTH-1]}}, mix_i});

      rs_p[c] = pc_r[c] + RND_P;
      e[c]    = rs_p[c][MPW-1:MIX_FRAC];
      ysum[c] = $signed({{(YW-SW){xc_r[c][SW-1]}}, xc_r[c]}) +
                $signed({e[c][EW-1], e[c]});
      if (ysum[c] > MAX_Y) begin
        y_nxt[c] = MAX_Y[SW-1:0];
      end else if (ysum[c] < MIN_Y) begin
        y_nxt[c] = MIN_Y[SW-1:0];
      end else begin
        y_nxt[c] = ysum[c][SW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= up_valid;
      end
      for (int i = 1; i < NSUB; i++) begin
        if (rdy[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      xa_r   <= x_i;
      acca_r <= acca_nxt;
    end
    if (rdy[1]) begin
      xb_r <= xa_r;
      sb_r <= sb_nxt;
    end
    if (rdy[2]) begin
      xc_r <= xb_r;
      pc_r <= pc_nxt;
    end
    if (rdy[3]) begin
      y_r <= y_nxt;
    end
  end

  assign y_o = y_r;

endmodule

// ----- hdl/chebyshev_harmonic_shaper_unit.sv -----
// Top level of the Chebyshev harmonic shaper: configuration registers, the
// chain of recurrence stages and the mix tail. Depends on chs_pkg,
// chs_order_stage and chs_mix_stage.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    in_left_sample, in_right_sample
//   out      out_valid / out_ready  out_left_out, out_right_out
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One stereo frame per cycle while the output does not stall; one stage per
// recurrence order from 2 to HIGHEST_ORDER, each holding one recurrence multiply
// and one weight multiply, then four tail stages (last weight, round, mix
// multiply, add and saturate). Reset clears every valid bit, zeroes the weights
// and sets the mix to 1.0. A stage loads when it is empty or the stage after it
// moves, so bubbles close up under a stall and in_ready stays high whenever the
// output register is empty or being taken. cfg_ready is always high.
module chebyshev_harmonic_shaper_unit #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int WEIGHT_WIDTH  = 16,
  parameter int HIGHEST_ORDER = 13
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]        in_right_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]        out_left_out,
  output logic signed [SAMPLE_WIDTH-1:0]        out_right_out,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [chs_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [chs_pkg::CFG_DATA_WIDTH-1:0]    cfg_data
);
  import chs_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int WW  = WEIGHT_WIDTH;
  localparam int TW  = SW + 1;
  localparam int AW  = SW + WW + 6;
  localparam int NST = HIGHEST_ORDER - 1;

  localparam logic signed [TW-1:0] T_ZERO = TW'(1) << (SW - 1);

  logic [CFG_DATA_WIDTH-1:0]   weights_low_r;
  logic [CFG_DATA_WIDTH-1:0]   weights_mid_r;
  logic [CFG_DATA_WIDTH-1:0]   weights_high_r;
  logic [MIX_WIDTH-1:0]        mix_amount_r;
  logic [3*CFG_DATA_WIDTH-1:0] lanes;

  logic signed [SW-1:0] x_w    [NST+1][CHANNELS];
  logic signed [TW-1:0] prev_w [NST+1][CHANNELS];
  logic signed [TW-1:0] cur_w  [NST+1][CHANNELS];
  logic signed [AW-1:0] acc_w  [NST+1][CHANNELS];
  logic signed [WW-1:0] gain_w [NST];
  logic signed [WW-1:0] gain_last;
  logic signed [SW-1:0] y_w    [CHANNELS];
  logic [NST:0]         vld_w;
  logic [NST:0]         rdy_w;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weights_low_r  <= '0;
      weights_mid_r  <= '0;
      weights_high_r <= '0;
      mix_amount_r   <= MIX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WEIGHTS_LOW:  weights_low_r  <= cfg_data;
        REG_WEIGHTS_MID:  weights_mid_r  <= cfg_data;
        REG_WEIGHTS_HIGH: weights_high_r <= cfg_data;
        REG_MIX_AMOUNT:   mix_amount_r   <= cfg_data[MIX_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // order n takes lane n-2 counted from the low register
  assign lanes     = {weights_high_r, weights_mid_r, weights_low_r};
  assign gain_last = lanes[LANE_WIDTH*(HIGHEST_ORDER-2) +: WW];

  assign vld_w[0]          = in_valid;
  assign in_ready          = rdy_w[0];
  assign x_w[0][CH_LEFT]   = in_left_sample;
  assign x_w[0][CH_RIGHT]  = in_right_sample;

  // seed the recurrence with T(0) = 1.0 and T(1) = x
  for (genvar c = 0; c < CHANNELS; c++) begin : g_seed
    assign prev_w[0][c] = T_ZERO;
    assign cur_w[0][c]  = {x_w[0][c][SW-1], x_w[0][c]};
    assign acc_w[0][c]  = '0;
  end

  for (genvar j = 0; j < NST; j++) begin : g_order
    // stage j makes T(j+2) and weights the harmonic of order j+1
    if (j == 0) begin : g_first
      assign gain_w[j] = '0;
    end else begin : g_rest
      assign gain_w[j] = lanes[LANE_WIDTH*(j-1) +: WW];
    end

    chs_order_stage #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .WEIGHT_WIDTH (WEIGHT_WIDTH),
      .ORDER        (j + 2)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_w[j]),
      .up_ready (rdy_w[j]),
      .dn_valid (vld_w[j+1]),
      .dn_ready (rdy_w[j+1]),
      .gain_i   (gain_w[j]),
      .x_i      (x_w[j]),
      .prev_i   (prev_w[j]),
      .cur_i    (cur_w[j]),
      .acc_i    (acc_w[j]),
      .x_o      (x_w[j+1]),
      .prev_o   (prev_w[j+1]),
      .cur_o    (cur_w[j+1]),
      .acc_o    (acc_w[j+1])
    );
  end

  chs_mix_stage #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .WEIGHT_WIDTH (WEIGHT_WIDTH),
    .ORDER        (HIGHEST_ORDER)
  ) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld_w[NST]),
    .up_ready (rdy_w[NST]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .gain_i   (gain_last),
    .mix_i    (mix_amount_r),
    .x_i      (x_w[NST]),
    .cur_i    (cur_w[NST]),
    .acc_i    (acc_w[NST]),
    .y_o      (y_w)
  );

  assign out_left_out  = y_w[CH_LEFT];
  assign out_right_out = y_w[CH_RIGHT];

endmodule

// ----- hdl/chs_checker.sv -----
// Port-level checks for the harmonic shaper top level, attached by bind.
// Depends on the ports of chebyshev_harmonic_shaper_unit only.
module chs_checker #(
  parameter int SAMPLE_WIDTH = 24
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_left_out,
  input logic [SAMPLE_WIDTH-1:0] out_right_out,
  input logic                    cfg_valid,
  input logic                    cfg_ready
);

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // with the output free the whole pipeline advances, so input is taken
  a_ready_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("in_ready low while the output stage can move");

  // register writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("cfg write stalled");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_left_out) && $stable(out_right_out)))
    else $error("result item changed while stalled");

  // ready is known whenever an input item is offered
  a_in_known: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid |-> !$isunknown(in_ready))
    else $error("in_ready unknown while an item is offered");

endmodule

bind chebyshev_harmonic_shaper_unit chs_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_chs_checker (.*);

// ----- tb/sv/chs_frame_checker.sv -----
// Frame checker for the harmonic shaper: follows the config, input and output
// channels, predicts each shaped stereo frame and compares it. Depends on chs_pkg.
module chs_frame_checker #(
  parameter int SAMPLE_WIDTH  = 24,
  parameter int WEIGHT_WIDTH  = 16,
  parameter int HIGHEST_ORDER = 13
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_right_sample,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]      out_left_out,
  input  logic signed [SAMPLE_WIDTH-1:0]      out_right_out,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [chs_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [chs_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
  output int                                  frames_due,
  output int                                  error_count
);
  import chs_pkg::*;

  typedef struct {
    logic signed [SAMPLE_WIDTH-1:0] src_left;
    logic signed [SAMPLE_WIDTH-1:0] src_right;
    logic signed [SAMPLE_WIDTH-1:0] want_left;
    logic signed [SAMPLE_WIDTH-1:0] want_right;
  } shaped_frame_t;

  shaped_frame_t               shaped_due[$];
  logic [CFG_DATA_WIDTH-1:0]   w_low  = '0;
  logic [CFG_DATA_WIDTH-1:0]   w_mid  = '0;
  logic [CFG_DATA_WIDTH-1:0]   w_high = '0;
  logic signed [MIX_WIDTH-1:0] mix_gain = MIX_RESET;

  initial begin
    error_count = 0;
    frames_due  = 0;
  end

  task automatic flag_error(input string msg);
    $display("%0t ERROR %s", $time, msg);
    error_count++;
  endtask

  // round to nearest, ties toward +inf
  function automatic longint rnd_shr(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint sat_range(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint lane_gain(input int order);
    int                        k;
    logic [CFG_DATA_WIDTH-1:0] bank;
    logic [LANE_WIDTH-1:0]     lane;
    k    = order - 2;
    bank = (k < 4) ? w_low : ((k < 8) ? w_mid : w_high);
    lane = bank[LANE_WIDTH*(k % 4) +: LANE_WIDTH];
    return longint'($signed(lane[WEIGHT_WIDTH-1:0]));
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] shaped_sample(
    input logic signed [SAMPLE_WIDTH-1:0] smp
  );
    longint one, x, t_prev, t_cur, t_next, harm, acc, sum, excess, y;
    int     n;
    one    = longint'(1) << (SAMPLE_WIDTH - 1);
    x      = longint'(smp);
    t_prev = one;
    t_cur  = x;
    acc    = 0;
    for (n = 2; n <= HIGHEST_ORDER; n++) begin
      t_next = sat_range(rnd_shr(x * t_cur, SAMPLE_WIDTH - 2) - t_prev, -one, one);
      // even orders lose their constant term
      if (n % 4 == 2)
        harm = t_next + one;
      else if (n % 4 == 0)
        harm = t_next - one;
      else
        harm = t_next;
      acc    += harm * lane_gain(n);
      t_prev = t_cur;
      t_cur  = t_next;
    end
    sum    = rnd_shr(acc, WEIGHT_WIDTH - 2);
    excess = rnd_shr(sum * longint'(mix_gain), MIX_FRAC);
    y      = sat_range(x + excess, -(longint'(1) << (SAMPLE_WIDTH - 1)),
                       (longint'(1) << (SAMPLE_WIDTH - 1)) - 1);
    return y[SAMPLE_WIDTH-1:0];
  endfunction

  always @(posedge clk) begin
    shaped_frame_t f;
    if (!rst_n) begin
      w_low    = '0;
      w_mid    = '0;
      w_high   = '0;
      mix_gain = MIX_RESET;
      shaped_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WEIGHTS_LOW:  w_low    = cfg_data;
          REG_WEIGHTS_MID:  w_mid    = cfg_data;
          REG_WEIGHTS_HIGH: w_high   = cfg_data;
          REG_MIX_AMOUNT:   mix_gain = cfg_data[MIX_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        f.src_left   = in_left_sample;
        f.src_right  = in_right_sample;
        f.want_left  = shaped_sample(in_left_sample);
        f.want_right = shaped_sample(in_right_sample);
        shaped_due.push_back(f);
      end
      if (out_valid && out_ready) begin
        if (shaped_due.size() == 0) begin
          flag_error($sformatf("unexpected frame L %0d R %0d", out_left_out, out_right_out));
        end else begin
          f = shaped_due.pop_front();
          if (out_left_out !== f.want_left)
            flag_error($sformatf("left out %0d, want %0d (in %0d)",
                                 out_left_out, f.want_left, f.src_left));
          if (out_right_out !== f.want_right)
            flag_error($sformatf("right out %0d, want %0d (in %0d)",
                                 out_right_out, f.want_right, f.src_right));
        end
      end
    end
    frames_due = shaped_due.size();
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the harmonic shaper: clock, reset, register settings,
// frame stimulus, output back-pressure and the verdict.
// Depends on chs_pkg, chebyshev_harmonic_shaper_unit and chs_frame_checker.
module tb_top;
  import chs_pkg::*;

  localparam int SAMPLE_WIDTH     = 24;
  localparam int WEIGHT_WIDTH     = 16;
  localparam int HIGHEST_ORDER    = 13;
  localparam int CLK_PERIOD       = 4;
  localparam int DRAIN_CYCLES     = HIGHEST_ORDER + 8;
  localparam int TIMEOUT_CYCLES   = 600000;
  localparam int RANDOM_PHASES    = 8;
  localparam int FRAMES_PER_PHASE = 106;
  localparam int LONG_HOLD_CYCLES = 240;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_FIRST = 4'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED_LAST  = 4'd15;

  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_ONE = SAMPLE_WIDTH'(1);

  localparam logic [MIX_WIDTH-1:0] MIX_NEG_ONE = 16'hC000;
  localparam logic [MIX_WIDTH-1:0] MIX_NEG_TWO = 16'h8000;
  localparam logic [MIX_WIDTH-1:0] MIX_MAX     = 16'h7FFF;
  localparam logic [MIX_WIDTH-1:0] MIX_ZERO    = 16'h0000;

  localparam logic [CFG_DATA_WIDTH-1:0] LANES_MAX_POS = {4{16'h7FFF}};
  localparam logic [CFG_DATA_WIDTH-1:0] LANES_MAX_NEG = {4{16'h8000}};
  localparam logic [CFG_DATA_WIDTH-1:0] LANE1_UNITY   = 64'h0000_0000_4000_0000;

  logic                              clk;
  logic                              rst_n           = 1'b0;
  logic                              in_valid        = 1'b0;
  logic                              in_ready;
  logic signed [SAMPLE_WIDTH-1:0]    in_left_sample  = '0;
  logic signed [SAMPLE_WIDTH-1:0]    in_right_sample = '0;
  logic                              out_valid;
  logic                              out_ready       = 1'b0;
  logic signed [SAMPLE_WIDTH-1:0]    out_left_out;
  logic signed [SAMPLE_WIDTH-1:0]    out_right_out;
  logic                              cfg_valid       = 1'b0;
  logic                              cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0]        cfg_index       = '0;
  logic [CFG_DATA_WIDTH-1:0]         cfg_data        = '0;

  int frames_due;
  int errors;
  bit no_idle      = 1'b0;
  bit hold_off_req = 1'b0;

  chebyshev_harmonic_shaper_unit #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .WEIGHT_WIDTH  (WEIGHT_WIDTH),
    .HIGHEST_ORDER (HIGHEST_ORDER)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  chs_frame_checker #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .WEIGHT_WIDTH  (WEIGHT_WIDTH),
    .HIGHEST_ORDER (HIGHEST_ORDER)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_left_sample  (in_left_sample),
    .in_right_sample (in_right_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_out    (out_left_out),
    .out_right_out   (out_right_out),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .frames_due      (frames_due),
    .error_count     (errors)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("[FAIL] regression broken");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 45)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
    int          r;
    logic [31:0] raw;
    r   = $urandom_range(0, 19);
    raw = $urandom();
    case (r)
      0:       return SAMPLE_MIN;
      1:       return SAMPLE_MAX;
      2:       return '0;
      3, 4, 5: begin
        raw = $urandom_range(0, 2047) - 1024;
        return raw[SAMPLE_WIDTH-1:0];
      end
      6:       return SAMPLE_MAX - SAMPLE_WIDTH'($urandom_range(0, 65535));
      7:       return SAMPLE_MIN + SAMPLE_WIDTH'($urandom_range(0, 65535));
      default: return raw[SAMPLE_WIDTH-1:0];
    endcase
  endfunction

  function automatic logic [CFG_DATA_WIDTH-1:0] pick_weights();
    logic [CFG_DATA_WIDTH-1:0] w;
    logic [31:0]               raw;
    int                        i;
    int                        r;
    w = '0;
    for (i = 0; i < 4; i++) begin
      r   = $urandom_range(0, 9);
      raw = $urandom();
      if (r < 3)
        raw = '0;
      else if (r < 7)
        raw = $urandom_range(0, 4095) - 2048;
      w[LANE_WIDTH*i +: LANE_WIDTH] = raw[LANE_WIDTH-1:0];
    end
    return w;
  endfunction

  // mix in the upper data bits is junk that must be ignored
  function automatic logic [CFG_DATA_WIDTH-1:0] pick_mix();
    logic [CFG_DATA_WIDTH-1:0] d;
    logic [31:0]               raw;
    int                        r;
    d   = {$urandom(), $urandom()};
    raw = $urandom();
    r   = $urandom_range(0, 9);
    if (r < 5) begin
      raw = $urandom_range(0, 32768) - 16384;
    end else if (r < 8) begin
      case ($urandom_range(0, 4))
        0:       raw[MIX_WIDTH-1:0] = MIX_RESET;
        1:       raw[MIX_WIDTH-1:0] = MIX_NEG_ONE;
        2:       raw[MIX_WIDTH-1:0] = MIX_NEG_TWO;
        3:       raw[MIX_WIDTH-1:0] = MIX_MAX;
        default: raw[MIX_WIDTH-1:0] = MIX_ZERO;
      endcase
    end
    d[MIX_WIDTH-1:0] = raw[MIX_WIDTH-1:0];
    return d;
  endfunction

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(input logic [CFG_INDEX_WIDTH-1:0] index,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_WIDTH-1:0] wl,
                                input logic [CFG_DATA_WIDTH-1:0] wm,
                                input logic [CFG_DATA_WIDTH-1:0] wh,
                                input logic [CFG_DATA_WIDTH-1:0] mix,
                                input bit                        with_unmapped);
    cfg_write(REG_WEIGHTS_LOW, wl);
    cfg_write(REG_WEIGHTS_MID, wm);
    cfg_write(REG_WEIGHTS_HIGH, wh);
    cfg_write(REG_MIX_AMOUNT, mix);
    if (with_unmapped)
      cfg_write($urandom_range(0, 1) ? REG_UNMAPPED_LAST : REG_UNMAPPED_FIRST,
                {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic signed [SAMPLE_WIDTH-1:0] l,
                            input logic signed [SAMPLE_WIDTH-1:0] r);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_frames_out();
    in_valid <= 1'b0;
    do @(posedge clk); while (frames_due != 0);
  endtask

  initial begin : result_sink
    int burst;
    int gap;
    bit held_long;
    held_long = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      burst = no_idle ? 200 : $urandom_range(1, 30);
      out_ready <= 1'b1;
      while (burst > 0) begin
        @(posedge clk);
        if (out_valid && out_ready)
          burst--;
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (hold_off_req && !held_long) begin
        gap       = LONG_HOLD_CYCLES;
        held_long = 1'b1;
      end else begin
        gap = idle_gap();
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    int p;
    int i;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: no weights, output follows input
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame('0, '1);
    send_frame(SAMPLE_ONE, '0);
    send_frame(pick_sample(), pick_sample());
    wait_frames_out();

    // strongest positive gains, drive into saturation
    apply_settings(LANES_MAX_POS, LANES_MAX_POS, LANES_MAX_POS, {48'd0, MIX_RESET}, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame('0, '1);
    send_frame(SAMPLE_ONE, '0);
    send_frame(SAMPLE_MAX >>> 1, SAMPLE_MIN >>> 1);
    send_frame(pick_sample(), pick_sample());
    wait_frames_out();

    // strongest negative gains with mix at -2.0
    apply_settings(LANES_MAX_NEG, LANES_MAX_NEG, LANES_MAX_NEG, {48'd0, MIX_NEG_TWO}, 1'b0);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(SAMPLE_MAX, SAMPLE_MIN);
    send_frame('0, '1);
    send_frame(SAMPLE_MAX >>> 2, SAMPLE_MIN >>> 2);
    send_frame(pick_sample(), pick_sample());
    wait_frames_out();

    // third harmonic alone, largest mix, then junk to unmapped indexes
    apply_settings(LANE1_UNITY, '0, '0, {{48{1'b1}}, MIX_MAX}, 1'b1);
    @(posedge clk);
    apply_settings(LANE1_UNITY, '0, '0, {48'd0, MIX_MAX}, 1'b1);
    send_frame(SAMPLE_MAX >>> 1, SAMPLE_MIN >>> 1);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(pick_sample(), pick_sample());
    send_frame(pick_sample(), pick_sample());
    wait_frames_out();

    // mix at -1.0 subtracts the third harmonic instead of adding it
    apply_settings(LANE1_UNITY, '0, '0, {48'd0, MIX_NEG_ONE}, 1'b0);
    send_frame(SAMPLE_MAX >>> 1, SAMPLE_MIN >>> 1);
    send_frame(SAMPLE_MIN, SAMPLE_MAX);
    send_frame(pick_sample(), pick_sample());
    wait_frames_out();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      no_idle = (p == 5);
      apply_settings(pick_weights(), pick_weights(), pick_weights(), pick_mix(), p % 3 == 1);
      for (i = 0; i < FRAMES_PER_PHASE; i++) begin
        if (p == 2 && i == 20)
          hold_off_req = 1'b1;
        send_frame(pick_sample(), pick_sample());
      end
      wait_frames_out();
    end
    no_idle = 1'b0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
